### rtl/step_detector_unit_assert.svh
// Assertion macros for the step detector unit.
// Used by files that carry concurrent checks; they expect i_clk and i_rst_n in scope.
`ifndef STEP_DETECTOR_UNIT_ASSERT_SVH
`define STEP_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SDU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("step detector check failed");

// next-cycle implication
`define SDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("step detector check failed");

`endif

### rtl/sdu_pkg.sv
// Shared types and constants of the step detector unit.
// No dependencies.
`timescale 1ns / 1ps

package sdu_pkg;

    localparam int ALPHA_BITS = 16;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam int CNT_W = 5;
    localparam int SQ_STEPS = 4;
    localparam int SQRT_STEPS = 16;
    localparam int MUL_STEPS = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_ALPHA   = 3'd0,
        CFG_LOW_THRESHOLD  = 3'd1,
        CFG_HIGH_THRESHOLD = 3'd2,
        CFG_MIN_INTERVAL   = 3'd3,
        CFG_MAX_INTERVAL   = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_accel;

    typedef struct packed {
        logic start;
        logic first;
        logic ack;
    } t_core_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

### rtl/step_detector_unit.sv
// Pedometer step detector: config registers, detector state, stream ports, result register.
// Depends on sdu_pkg and sdu_core; assertions from step_detector_unit_assert.svh.
// One sample at a time: the next sample is accepted only after the previous result
// commits, since the square-root and shift-add filter loops run on the shared adder;
// the filter multiply and sum steps are skipped while the filter is unseeded.
// Reset: synchronous active low; clears detector state and restores register defaults.
`timescale 1ns / 1ps
`include "step_detector_unit_assert.svh"

module step_detector_unit #(
    parameter int FILTER_FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sdu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sdu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [79:0]                     s_axis_tdata,  // accel_x, accel_y, accel_z, time_ms
    input  logic [0:0]                      s_axis_tuser,  // sample_valid
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [47:0]                     m_axis_tdata,  // step_total, smoothed_magnitude
    output logic [0:0]                      m_axis_tuser   // step_detected
);

    import sdu_pkg::*;

    localparam int SW = 16 + FILTER_FRACTION_BITS;

    logic [16:0]   r_alpha;
    logic [15:0]   r_low, r_high, r_min, r_max;

    logic          r_in_valid;
    logic [31:0]   r_time;

    logic          r_filter_ready, n_filter_ready;
    logic [SW-1:0] r_smooth, n_smooth;
    logic          r_armed, n_armed;
    logic          r_have, n_have;
    logic [31:0]   r_prev, n_prev;
    logic [31:0]   r_count, n_count;
    logic          w_det;

    logic          r_out_valid;
    logic          r_out_det;
    logic [31:0]   r_out_total;
    logic [15:0]   r_out_smooth;

    t_core_ctrl    w_ctrl;
    t_core_stat    w_stat;
    t_accel        w_accel;
    logic [16:0]   w_alpha;
    logic [SW-1:0] w_s_new;
    logic [31:0]   w_interval;
    logic          w_in_acc, w_commit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 17'd13107;
            r_low   <= 16'd1050;
            r_high  <= 16'd1150;
            r_min   <= 16'd250;
            r_max   <= 16'd2000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILTER_ALPHA:   r_alpha <= i_cfg_data;
                CFG_LOW_THRESHOLD:  r_low   <= i_cfg_data[15:0];
                CFG_HIGH_THRESHOLD: r_high  <= i_cfg_data[15:0];
                CFG_MIN_INTERVAL:   r_min   <= i_cfg_data[15:0];
                CFG_MAX_INTERVAL:   r_max   <= i_cfg_data[15:0];
                default:            r_alpha <= r_alpha;
            endcase
        end
    end

    assign w_alpha = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    assign s_axis_tready = w_stat.idle;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = w_stat.done && (!r_out_valid || m_axis_tready);

    assign w_accel.x = s_axis_tdata[15:0];
    assign w_accel.y = s_axis_tdata[31:16];
    assign w_accel.z = s_axis_tdata[47:32];

    assign w_ctrl.start = w_in_acc;
    assign w_ctrl.first = !r_filter_ready;
    assign w_ctrl.ack   = w_commit;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_valid <= s_axis_tuser[0];
            r_time     <= s_axis_tdata[79:48];
        end
    end

    sdu_core #(
        .FRAC_BITS (FILTER_FRACTION_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_accel (w_accel),
        .i_alpha (w_alpha),
        .i_s_old (r_smooth),
        .o_stat  (w_stat),
        .o_s_new (w_s_new)
    );

    assign w_interval = r_time - r_prev;

    always_comb begin
        n_filter_ready = r_filter_ready;
        n_smooth       = r_smooth;
        n_armed        = r_armed;
        n_have         = r_have;
        n_prev         = r_prev;
        n_count        = r_count;
        w_det          = 1'b0;
        if (r_in_valid) begin
            n_filter_ready = 1'b1;
            n_smooth       = w_s_new;
            if (w_s_new <= {r_low, {FILTER_FRACTION_BITS{1'b0}}}) begin
                n_armed = 1'b1;
            end
            if (n_armed && (w_s_new >= {r_high, {FILTER_FRACTION_BITS{1'b0}}})) begin
                n_armed = 1'b0;
                if (!(r_have && (w_interval < 32'(r_min)))) begin
                    // stale history clear, overridden by the new step
                    n_have = r_have && !(w_interval > 32'(r_max));
                    n_have = 1'b1;
                    n_prev = r_time;
                    if (r_count != '1) begin
                        n_count = r_count + 32'd1;
                    end
                    w_det = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_ready <= 1'b0;
            r_smooth       <= '0;
            r_armed        <= 1'b0;
            r_have         <= 1'b0;
            r_prev         <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_commit) begin
                r_filter_ready <= n_filter_ready;
                r_smooth       <= n_smooth;
                r_armed        <= n_armed;
                r_have         <= n_have;
                r_prev         <= n_prev;
                r_count        <= n_count;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_det    <= w_det;
            r_out_total  <= n_count;
            r_out_smooth <= n_smooth[SW-1:FILTER_FRACTION_BITS];
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out_det;
    assign m_axis_tdata    = {r_out_smooth, r_out_total};

    `SDU_ASSERT_IMPL(a_busy_not_ready, w_stat.done, !s_axis_tready)
    `SDU_ASSERT_NEXT(a_done_holds, w_stat.done && !w_commit, w_stat.done)
    `SDU_ASSERT_NEXT(a_commit_shows, w_commit, m_axis_tvalid)
    `SDU_ASSERT_IMPL(a_step_counted, r_out_valid && r_out_det, r_out_total != 32'd0)

endmodule

### rtl/sdu_alu.sv
// Shared add/subtract unit of the step detector.
// No dependencies.
`timescale 1ns / 1ps

module sdu_alu #(
    parameter int W = 50
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_neg
);

    assign o_sum = i_sub ? (i_a - i_b) : (i_a + i_b);
    assign o_neg = o_sum[W-1];

endmodule

### rtl/sdu_core.sv
// Sequencer and datapath: squares, bit-serial square root, shift-add filter update.
// Depends on sdu_pkg and sdu_alu.
`timescale 1ns / 1ps

module sdu_core #(
    parameter int FRAC_BITS = 16,
    localparam int SW = 16 + FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdu_pkg::t_core_ctrl i_ctrl,
    input  sdu_pkg::t_accel     i_accel,
    input  logic [16:0]         i_alpha,
    input  logic [SW-1:0]       i_s_old,
    output sdu_pkg::t_core_stat o_stat,
    output logic [SW-1:0]       o_s_new
);

    import sdu_pkg::*;

    localparam int AW = SW + 18;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    t_accel             r_accel;
    logic [31:0]        r_prod;
    logic [31:0]        r_rad;
    logic [17:0]        r_rem;
    logic [15:0]        r_q;
    logic [AW-1:0]      r_mcand;
    logic [16:0]        r_mplier;
    logic [AW-1:0]      r_acc;
    logic [SW-1:0]      r_snew;

    logic signed [15:0] w_mop;
    logic signed [31:0] w_sq;
    logic [19:0]        w_rs;
    logic [SW-1:0]      w_target;
    logic [AW-1:0]      w_alu_a, w_alu_b, w_alu_y;
    logic               w_alu_sub, w_alu_neg;

    always_comb begin
        case (r_cnt[1:0])
            2'd1:    w_mop = r_accel.y;
            2'd2:    w_mop = r_accel.z;
            default: w_mop = r_accel.x;
        endcase
    end

    assign w_sq     = w_mop * w_mop;
    assign w_rs     = {r_rem, r_rad[31:30]};
    assign w_target = {r_q, {FRAC_BITS{1'b0}}};

    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            ST_SQUARE: begin
                w_alu_a = (r_cnt == CNT_W'(1)) ? '0 : AW'(r_rad);
                w_alu_b = AW'(r_prod);
            end
            ST_ROOT: begin
                w_alu_a   = AW'(w_rs);
                w_alu_b   = AW'({r_q, 2'b01});
                w_alu_sub = 1'b1;
            end
            ST_DIFF: begin
                w_alu_a   = AW'(w_target);
                w_alu_b   = AW'(i_s_old);
                w_alu_sub = 1'b1;
            end
            ST_MUL: begin
                w_alu_a = r_acc;
                w_alu_b = r_mcand;
            end
            ST_SUM: begin
                w_alu_a = AW'(i_s_old);
                w_alu_b = AW'($signed(r_acc) >>> ALPHA_BITS);
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    sdu_alu #(
        .W (AW)
    ) u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_sum (w_alu_y),
        .o_neg (w_alu_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_ctrl.start) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end
            end
            ST_ROOT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DIFF;
                    n_cnt   = '0;
                end
            end
            ST_DIFF: begin
                n_cnt   = '0;
                n_state = i_ctrl.first ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = ST_SUM;
                    n_cnt   = '0;
                end
            end
            ST_SUM: begin
                n_state = ST_DONE;
                n_cnt   = '0;
            end
            ST_DONE: begin
                n_cnt = '0;
                if (i_ctrl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    r_accel <= i_accel;
                end
            end
            ST_SQUARE: begin
                if (r_cnt != CNT_W'(SQ_STEPS - 1)) begin
                    r_prod <= w_sq;
                end
                if (r_cnt != '0) begin
                    r_rad <= w_alu_y[31:0];
                end
                r_rem <= '0;
                r_q   <= '0;
            end
            ST_ROOT: begin
                r_rad <= {r_rad[29:0], 2'b00};
                if (!w_alu_neg) begin
                    r_rem <= w_alu_y[17:0];
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= w_rs[17:0];
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
            ST_DIFF: begin
                r_snew   <= w_target;
                r_mcand  <= w_alu_y;
                r_mplier <= i_alpha;
                r_acc    <= '0;
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= w_alu_y;
                end
                r_mcand  <= {r_mcand[AW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[16:1]};
            end
            ST_SUM: begin
                r_snew <= w_alu_y[SW-1:0];
            end
            default: begin
                r_snew <= r_snew;
            end
        endcase
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_s_new     = r_snew;

endmodule

### bench/step_detector_checker.sv
// Checker for the step detector unit: watches the config, sample and result channels.
// Predicts each result from its own copy of the detector state; depends on sdu_pkg.
`timescale 1ns / 1ps

module step_detector_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [sdu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sdu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [79:0]                     s_axis_tdata,  // accel_x, accel_y, accel_z, time_ms
    input  logic [0:0]                      s_axis_tuser,  // sample_valid
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [47:0]                     m_axis_tdata,  // step_total, smoothed_magnitude
    input  logic [0:0]                      m_axis_tuser,  // step_detected
    output int                              o_pending,
    output int                              o_fail_count
);

    import sdu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        detected;
        logic [31:0] total;
        logic [15:0] smoothed;
    } t_step_result;

    logic [16:0] alpha_q;
    logic [15:0] low_q;
    logic [15:0] high_q;
    logic [15:0] min_gap_q;
    logic [15:0] max_gap_q;

    logic        seeded;
    logic [63:0] level;
    logic        armed;
    logic        have_step;
    logic [31:0] last_step_ms;
    logic [31:0] steps;

    t_step_result expected_results [$];
    int           mismatches = 0;

    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] rem;
        logic [31:0] root;
        logic [31:0] probe;
        rem   = v;
        root  = 0;
        probe = 32'h4000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_step_result detect_step(input t_accel acc, input logic vld,
                                                 input logic [31:0] t);
        logic [31:0]  sum;
        logic [31:0]  interval;
        logic [63:0]  target;
        logic [63:0]  weight;
        t_step_result r;
        r.detected = 1'b0;
        if (vld) begin
            sum = 32'(int'(acc.x) * int'(acc.x)) + 32'(int'(acc.y) * int'(acc.y))
                + 32'(int'(acc.z) * int'(acc.z));
            target = 64'(floor_sqrt(sum)) << FRAC_BITS;
            if (!seeded) begin
                level  = target;
                seeded = 1'b1;
            end else begin
                weight = (alpha_q > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_q);
                level  = (level * (64'(ALPHA_ONE) - weight) + target * weight) >> ALPHA_BITS;
            end
            if (level <= (64'(low_q) << FRAC_BITS))
                armed = 1'b1;
            if (armed && level >= (64'(high_q) << FRAC_BITS)) begin
                interval = t - last_step_ms;
                armed    = 1'b0;
                if (!(have_step && interval < 32'(min_gap_q))) begin
                    if (have_step && interval > 32'(max_gap_q))
                        have_step = 1'b0;
                    last_step_ms = t;
                    have_step    = 1'b1;
                    if (steps != '1)
                        steps = steps + 1;
                    r.detected = 1'b1;
                end
            end
        end
        r.total    = steps;
        r.smoothed = ((level >> FRAC_BITS) > 64'hFFFF) ? 16'hFFFF : 16'(level >> FRAC_BITS);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            alpha_q      = 17'd13107;
            low_q        = 16'd1050;
            high_q       = 16'd1150;
            min_gap_q    = 16'd250;
            max_gap_q    = 16'd2000;
            seeded       = 1'b0;
            level        = '0;
            armed        = 1'b0;
            have_step    = 1'b0;
            last_step_ms = '0;
            steps        = '0;
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[47:32]};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: detected %0d total %0d smoothed %0d",
                                 got.detected, got.total, got.smoothed);
                end else begin
                    want = expected_results.pop_front();
                    if (got.detected !== want.detected || got.total !== want.total ||
                        got.smoothed !== want.smoothed) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result mismatch (exp/act): detected %0d/%0d ",
                                      "total %0d/%0d smoothed %0d/%0d"},
                                     want.detected, got.detected, want.total, got.total,
                                     want.smoothed, got.smoothed);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILTER_ALPHA:   alpha_q   = i_cfg_data;
                    CFG_LOW_THRESHOLD:  low_q     = i_cfg_data[15:0];
                    CFG_HIGH_THRESHOLD: high_q    = i_cfg_data[15:0];
                    CFG_MIN_INTERVAL:   min_gap_q = i_cfg_data[15:0];
                    CFG_MAX_INTERVAL:   max_gap_q = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(detect_step(t_accel'(s_axis_tdata[47:0]),
                                                       s_axis_tuser[0], s_axis_tdata[79:48]));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

### bench/tb_step_detector_unit.sv
// Testbench top for the step detector unit: clock, reset, stimulus and verdict.
// Depends on sdu_pkg, step_detector_unit and step_detector_checker.
`timescale 1ns / 1ps

module tb_step_detector_unit;

    import sdu_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 60;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [79:0]            s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [47:0]            m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    int          pending;
    int          fail_count;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    logic        tx_gaps     = 1'b1;
    logic        rx_stalls   = 1'b1;
    logic [31:0] now_ms      = '0;
    int          step_ms_max = 200;
    int          cur_low     = 1050;
    int          cur_high    = 1150;

    always #5 i_clk = ~i_clk;

    step_detector_unit #(
        .FILTER_FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    step_detector_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [15:0] x, y, z, input logic vld,
                               input logic [31:0] t);
        int g;
        g = tx_gaps ? idle_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, z, y, x};
        s_axis_tuser  <= vld;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_mag(input int m);
        logic signed [15:0] comp [3];
        int                 axis;
        int                 mag;
        mag  = (m > 32767) ? 32767 : m;
        axis = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            comp[i] = 16'(int'($urandom_range(0, 30)) - 15);
        comp[axis] = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
        now_ms     = now_ms + 32'($urandom_range(0, step_ms_max));
        send_sample(comp[0], comp[1], comp[2], $urandom_range(0, 19) != 0, now_ms);
    endtask

    // strides of low then high magnitude, salted with random samples
    task automatic walk(input int n_items);
        int sent;
        int reps;
        int hi_top;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1))
                    now_ms = $urandom;
                send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom_range(0, 1)), now_ms);
                sent++;
            end else begin
                reps = $urandom_range(1, 3);
                repeat (reps) send_mag($urandom_range(0, cur_low));
                sent += reps;
                hi_top = (cur_high + 1500 > 32767) ? 32767 : cur_high + 1500;
                reps   = $urandom_range(1, 3);
                repeat (reps) send_mag($urandom_range(cur_high, hi_top));
                sent += reps;
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [16:0] alpha, input logic [15:0] low, high,
                             input logic [15:0] min_gap, max_gap, input logic junk);
        write_reg(CFG_FILTER_ALPHA, alpha);
        write_reg(CFG_LOW_THRESHOLD, 17'(low));
        write_reg(CFG_HIGH_THRESHOLD, 17'(high));
        write_reg(CFG_MIN_INTERVAL, 17'(min_gap));
        write_reg(CFG_MAX_INTERVAL, 17'(max_gap));
        if (junk)
            write_reg(3'(CFG_MAX_INTERVAL) + 3'($urandom_range(1, 3)), 17'($urandom));
        i_cfg_valid <= 1'b0;
        cur_low  = int'(low);
        cur_high = int'(high);
    endtask

    initial begin
        logic [31:0] t0;
        logic [15:0] lo;
        t0 = 32'hFFFF_FF00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: invalid before seeding, seed at full scale, extremes
        send_sample(-16'sd1, -16'sd1, -16'sd1, 1'b0, 32'hFFFF_FFFF);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 32'd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 32'd1);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd5);
        send_sample(16'sd32767, 16'sd0, 16'sd0, 1'b0, 32'd6);
        drain_results();

        // unit alpha: exact thresholds, rejected step, interval across the wrap
        configure(17'h10000, 16'd1050, 16'd1150, 16'd250, 16'd2000, 1'b0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, t0);
        send_sample(16'sd1150, 16'sd0, 16'sd0, 1'b1, t0);
        send_sample(16'sd1050, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd20));
        send_sample(16'sd1149, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd50));
        send_sample(16'sd1150, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd100));
        send_sample(16'sd0, -16'sd1200, 16'sd0, 1'b1, 32'(t0 + 32'd300));
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd310));
        send_sample(16'sd0, 16'sd0, 16'sd2000, 1'b0, 32'(t0 + 32'd315));
        send_sample(16'sd0, 16'sd0, 16'sd2000, 1'b1, 32'(t0 + 32'd320));
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd330));
        send_sample(-16'sd2000, 16'sd0, 16'sd0, 1'b1, 32'(t0 + 32'd570));
        drain_results();
        now_ms = 32'(t0 + 32'd600);

        configure(17'h10000, 16'd900, 16'd1200, 16'd300, 16'd2000, 1'b1);
        step_ms_max = 200;
        walk(90);
        drain_results();

        // alpha above one, always armed, always firing, longest min interval
        configure(17'h1FFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1);
        tx_gaps     <= 1'b0;
        rx_stalls   <= 1'b0;
        step_ms_max = 70000;
        walk(60);
        drain_results();

        // alpha zero freezes the filter
        configure(17'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        tx_gaps     <= 1'b1;
        rx_stalls   <= 1'b1;
        step_ms_max = 100;
        walk(30);
        drain_results();

        for (int round = 0; round < 3; round++) begin
            lo = 16'($urandom_range(200, 1500));
            configure(17'($urandom_range(16384, 65536)), lo,
                      16'(lo + $urandom_range(0, 600)), 16'($urandom_range(0, 400)),
                      16'($urandom), 1'b1);
            tx_gaps     <= (round != 2);
            rx_stalls   <= (round != 1);
            step_ms_max = 150;
            walk(50);
            drain_results();
            walk(50);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
